// ===== hdl/hslp_pkg.sv =====
// Shared constants and types for the RGB to HSL pixel converter.
// No dependencies; used by hslp_div and rgb_to_hsl_pixel.
`timescale 1ns / 1ps

package hslp_pkg;

    localparam int PIX_W  = 8;
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 17;
    localparam int LSUM_W = 9;

    // Hue numerator before division, always nonnegative and below 360 * 256
    localparam int HNUM_W = 17;
    // Signed working width for the hue numerator
    localparam int HACC_W = 18;

    localparam int SAT_SHIFT = 16;
    localparam int BYTE_MAX  = 255;
    localparam int LSUM_MAX  = 510;

    localparam int HUE_STEP  = 60;
    localparam int HUE_GREEN = 120;
    localparam int HUE_BLUE  = 240;
    localparam int HUE_WRAP  = 360;

    // Pipelined restoring divider
    localparam int DIV_BPS    = 3;
    localparam int DIV_STAGES = 6;
    localparam int DIV_Q_W    = DIV_BPS * DIV_STAGES;
    localparam int DIV_DEN_W  = PIX_W;
    localparam int DIV_NUM_W  = DIV_Q_W + DIV_DEN_W - 1;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

endpackage

// ===== hdl/hslp_div.sv =====
// Pipelined restoring divider, a few quotient bits per register stage.
// Depends on hslp_pkg. Dividend must satisfy dividend < divisor * 2**DIV_Q_W.
`timescale 1ns / 1ps

module hslp_div
(
    input  logic                           clk,
    input  logic [hslp_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [hslp_pkg::DIV_DEN_W-1:0] divisor,
    output logic [hslp_pkg::DIV_Q_W-1:0]   quotient
);

    localparam int NST = hslp_pkg::DIV_STAGES;
    localparam int QW  = hslp_pkg::DIV_Q_W;
    localparam int DW  = hslp_pkg::DIV_DEN_W;
    localparam int NW  = hslp_pkg::DIV_NUM_W;

    logic [DW-1:0] rem_reg [NST];
    logic [QW-1:0] low_reg [NST];
    logic [QW-1:0] q_reg   [NST];
    logic [DW-1:0] dvs_reg [NST];

    logic [DW-1:0] rem_src [NST];
    logic [QW-1:0] low_src [NST];
    logic [QW-1:0] q_src   [NST];
    logic [DW-1:0] dvs_src [NST];

    logic [DW-1:0] rem_next [NST];
    logic [QW-1:0] low_next [NST];
    logic [QW-1:0] q_next   [NST];

    always_comb
    begin
        rem_src[0] = DW'(dividend[NW-1:QW]);
        low_src[0] = dividend[QW-1:0];
        q_src[0]   = '0;
        dvs_src[0] = divisor;
        for (int st = 1; st < NST; st++)
        begin
            rem_src[st] = rem_reg[st-1];
            low_src[st] = low_reg[st-1];
            q_src[st]   = q_reg[st-1];
            dvs_src[st] = dvs_reg[st-1];
        end
    end

    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] q;
        for (int st = 0; st < NST; st++)
        begin
            rem = rem_src[st];
            low = low_src[st];
            q   = q_src[st];
            for (int k = 0; k < hslp_pkg::DIV_BPS; k++)
            begin
                trial = {rem, low[QW-1]};
                low   = {low[QW-2:0], 1'b0};
                if (trial >= {1'b0, dvs_src[st]})
                begin
                    rem = DW'(trial - {1'b0, dvs_src[st]});
                    q   = {q[QW-2:0], 1'b1};
                end
                else
                begin
                    rem = trial[DW-1:0];
                    q   = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[st] = rem;
            low_next[st] = low;
            q_next[st]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int st = 0; st < NST; st++)
        begin
            rem_reg[st] <= rem_next[st];
            low_reg[st] <= low_next[st];
            q_reg[st]   <= q_next[st];
            dvs_reg[st] <= dvs_src[st];
        end
    end

    assign quotient = q_reg[NST-1];

endmodule

// ===== hdl/rgb_to_hsl_pixel.sv =====
// RGB to HSL pixel converter, top level.
// Depends on hslp_pkg and hslp_div.
//
// Usage:
//   Input: drive red, green, blue and pulse start. A word is taken at every
//   rising edge with start high and busy low; busy is always low, so a new
//   pixel may enter on every clock.
//   Output: done is high for exactly one cycle per pixel, with hue_deg,
//   saturation_frac and lightness_sum valid in that cycle. Results leave
//   in the order pixels entered.
//   Pipeline: a pixel passes through the input register, max/min select,
//   numerator build, six divider stages and the output register.
//   Throughput: one pixel per clock, set by the fully pipelined dividers
//   (3 quotient bits per stage) for saturation and hue.
//   Reset: rst_n clears all valid bits; no result is shown until a pixel
//   has passed through. Nothing needs clearing beyond that.
//   The receiver cannot stall; done is a strobe and must be taken.
`timescale 1ns / 1ps

module rgb_to_hsl_pixel
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hslp_pkg::PIX_W-1:0]    red,
    input  logic [hslp_pkg::PIX_W-1:0]    green,
    input  logic [hslp_pkg::PIX_W-1:0]    blue,
    output logic                          done,
    output logic [hslp_pkg::HUE_W-1:0]    hue_deg,
    output logic [hslp_pkg::SAT_W-1:0]    saturation_frac,
    output logic [hslp_pkg::LSUM_W-1:0]   lightness_sum
);

    localparam int PW  = hslp_pkg::PIX_W;
    localparam int AW  = hslp_pkg::HACC_W;
    localparam int NST = hslp_pkg::DIV_STAGES;
    localparam int LW  = hslp_pkg::LSUM_W;

    // stage 1: input register
    logic          v1_reg;
    logic [PW-1:0] r1_reg, g1_reg, b1_reg;

    // stage 2: max, min, which component is max, signed difference
    logic                 v2_reg;
    logic [PW-1:0]        mx2_reg, mn2_reg;
    hslp_pkg::max_sel_t   sel2_reg;
    logic signed [PW:0]   diff2_reg;

    logic [PW-1:0]        mx2_next, mn2_next;
    hslp_pkg::max_sel_t   sel2_next;
    logic signed [PW:0]   diff2_next;

    // stage 3: divider operands
    logic                              v3_reg;
    logic                              gray3_reg;
    logic [LW-1:0]                     s3_reg;
    logic [hslp_pkg::DIV_NUM_W-1:0]    sat_num3_reg, hue_num3_reg;
    logic [hslp_pkg::DIV_DEN_W-1:0]    sat_den3_reg, hue_den3_reg;

    logic [PW-1:0]                     d3_next;
    logic [LW-1:0]                     s3_next;
    logic [LW-1:0]                     s3_far;
    logic [hslp_pkg::DIV_DEN_W-1:0]    sat_den3_next;
    logic [AW-1:0]                     hnum3_next;

    // side band alongside the dividers
    logic          vd_reg    [NST];
    logic          grayd_reg [NST];
    logic [LW-1:0] sd_reg    [NST];

    logic [hslp_pkg::DIV_Q_W-1:0] sat_q, hue_q;

    // output register
    logic                        done_reg;
    logic [hslp_pkg::HUE_W-1:0]  hue_reg;
    logic [hslp_pkg::SAT_W-1:0]  sat_reg;
    logic [LW-1:0]               lsum_reg;

    logic [hslp_pkg::HUE_W-1:0]  hue_next;

    assign busy = 1'b0;

    // stage 2 logic
    always_comb
    begin
        if (r1_reg >= g1_reg && r1_reg >= b1_reg)
            sel2_next = hslp_pkg::SEL_RED;
        else if (g1_reg >= b1_reg)
            sel2_next = hslp_pkg::SEL_GREEN;
        else
            sel2_next = hslp_pkg::SEL_BLUE;

        unique case (sel2_next)
            hslp_pkg::SEL_RED:
            begin
                mx2_next   = r1_reg;
                diff2_next = $signed({1'b0, g1_reg}) - $signed({1'b0, b1_reg});
            end
            hslp_pkg::SEL_GREEN:
            begin
                mx2_next   = g1_reg;
                diff2_next = $signed({1'b0, b1_reg}) - $signed({1'b0, r1_reg});
            end
            hslp_pkg::SEL_BLUE:
            begin
                mx2_next   = b1_reg;
                diff2_next = $signed({1'b0, r1_reg}) - $signed({1'b0, g1_reg});
            end
            default:
            begin
                mx2_next   = '0;
                diff2_next = '0;
            end
        endcase

        mn2_next = (r1_reg <= g1_reg) ? r1_reg : g1_reg;
        if (b1_reg < mn2_next)
            mn2_next = b1_reg;
    end

    // stage 3 logic
    always_comb
    begin
        logic [AW-1:0] diff_ext;
        logic [AW-1:0] d_ext;
        logic [AW-1:0] ofs;
        d3_next  = mx2_reg - mn2_reg;
        s3_next  = LW'(mx2_reg) + LW'(mn2_reg);
        s3_far   = LW'(hslp_pkg::LSUM_MAX) - s3_next;
        sat_den3_next = (s3_next <= LW'(hslp_pkg::BYTE_MAX)) ? s3_next[PW-1:0]
                                                             : s3_far[PW-1:0];
        diff_ext = AW'(diff2_reg);
        d_ext    = AW'(d3_next);
        unique case (sel2_reg)
            hslp_pkg::SEL_RED:
                ofs = diff2_reg[PW] ? d_ext * AW'(hslp_pkg::HUE_WRAP) : '0;
            hslp_pkg::SEL_GREEN:
                ofs = d_ext * AW'(hslp_pkg::HUE_GREEN);
            hslp_pkg::SEL_BLUE:
                ofs = d_ext * AW'(hslp_pkg::HUE_BLUE);
            default:
                ofs = '0;
        endcase
        hnum3_next = ofs + diff_ext * AW'(hslp_pkg::HUE_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int st = 0; st < NST; st++)
                vd_reg[st] <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int st = 1; st < NST; st++)
                vd_reg[st] <= vd_reg[st-1];
            done_reg <= vd_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            r1_reg <= red;
            g1_reg <= green;
            b1_reg <= blue;
        end
        mx2_reg   <= mx2_next;
        mn2_reg   <= mn2_next;
        sel2_reg  <= sel2_next;
        diff2_reg <= diff2_next;

        gray3_reg    <= (d3_next == '0);
        s3_reg       <= s3_next;
        sat_num3_reg <= {1'b0, d3_next, hslp_pkg::SAT_SHIFT'(0)};
        sat_den3_reg <= sat_den3_next;
        hue_num3_reg <= hslp_pkg::DIV_NUM_W'(hnum3_next[hslp_pkg::HNUM_W-1:0]);
        hue_den3_reg <= d3_next;

        grayd_reg[0] <= gray3_reg;
        sd_reg[0]    <= s3_reg;
        for (int st = 1; st < NST; st++)
        begin
            grayd_reg[st] <= grayd_reg[st-1];
            sd_reg[st]    <= sd_reg[st-1];
        end

        hue_reg  <= grayd_reg[NST-1] ? '0 : hue_next;
        sat_reg  <= grayd_reg[NST-1] ? '0 : sat_q[hslp_pkg::SAT_W-1:0];
        lsum_reg <= sd_reg[NST-1];
    end

    hslp_div u_sat_div
    (
        .clk      (clk),
        .dividend (sat_num3_reg),
        .divisor  (sat_den3_reg),
        .quotient (sat_q)
    );

    hslp_div u_hue_div
    (
        .clk      (clk),
        .dividend (hue_num3_reg),
        .divisor  (hue_den3_reg),
        .quotient (hue_q)
    );

    always_comb
    begin
        hue_next = hue_q[hslp_pkg::HUE_W-1:0];
        if (hue_next >= hslp_pkg::HUE_W'(hslp_pkg::HUE_WRAP))
            hue_next = hue_next - hslp_pkg::HUE_W'(hslp_pkg::HUE_WRAP);
    end

    assign done            = done_reg;
    assign hue_deg         = hue_reg;
    assign saturation_frac = sat_reg;
    assign lightness_sum   = lsum_reg;

`ifndef ASSERT_OFF
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue_deg < hslp_pkg::HUE_W'(hslp_pkg::HUE_WRAP))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> saturation_frac <= hslp_pkg::SAT_W'(1 << hslp_pkg::SAT_SHIFT))
        else $error("saturation above one");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturation_frac == '0) |-> hue_deg == '0)
        else $error("hue nonzero on gray pixel");

    a_pipe_fill: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vd_reg[NST-1]))
        else $error("result without item in divider");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for rgb_to_hsl_pixel: a directed pixel table, then random pixels
// in bursts, each checked against its typed row or an integer HSL conversion made here.
// Depends on hslp_pkg and the rgb_to_hsl_pixel RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM  = 2000;
    localparam int N_ROWS    = 20;
    localparam int DRAIN_CYC = 16;

    typedef struct packed {
        logic [hslp_pkg::HUE_W-1:0]  hue;
        logic [hslp_pkg::SAT_W-1:0]  sat;
        logic [hslp_pkg::LSUM_W-1:0] lsum;
    } hsl_t;

    typedef struct packed {
        logic [hslp_pkg::PIX_W-1:0]  r;
        logic [hslp_pkg::PIX_W-1:0]  g;
        logic [hslp_pkg::PIX_W-1:0]  b;
        logic                        typed;
        logic [hslp_pkg::HUE_W-1:0]  hue;
        logic [hslp_pkg::SAT_W-1:0]  sat;
        logic [hslp_pkg::LSUM_W-1:0] lsum;
    } pixel_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [hslp_pkg::PIX_W-1:0]  red;
    logic [hslp_pkg::PIX_W-1:0]  green;
    logic [hslp_pkg::PIX_W-1:0]  blue;
    logic                        done;
    logic [hslp_pkg::HUE_W-1:0]  hue_deg;
    logic [hslp_pkg::SAT_W-1:0]  saturation_frac;
    logic [hslp_pkg::LSUM_W-1:0] lightness_sum;

    pixel_row_t directed_rows [N_ROWS];
    pixel_row_t cur_row;
    hsl_t       hsl_expected [$];
    int         mismatches = 0;
    int         failures   = 0;

    rgb_to_hsl_pixel dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .done            (done),
        .hue_deg         (hue_deg),
        .saturation_frac (saturation_frac),
        .lightness_sum   (lightness_sum)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic hsl_t hsl_convert(input logic [hslp_pkg::PIX_W-1:0] r8, g8, b8);
        int   ri;
        int   gi;
        int   bi;
        int   mx;
        int   mn;
        int   dlt;
        int   sum;
        int   div;
        int   num;
        hsl_t res;
        ri = int'(r8);
        gi = int'(g8);
        bi = int'(b8);
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        dlt = mx - mn;
        sum = mx + mn;
        res.hue  = '0;
        res.sat  = '0;
        res.lsum = hslp_pkg::LSUM_W'(sum);
        if (dlt > 0)
        begin
            div = (sum <= hslp_pkg::BYTE_MAX) ? sum : hslp_pkg::LSUM_MAX - sum;
            res.sat = hslp_pkg::SAT_W'((dlt << hslp_pkg::SAT_SHIFT) / div);
            if (ri == mx)
            begin
                num = hslp_pkg::HUE_STEP * (gi - bi);
                if (num < 0)
                    num += hslp_pkg::HUE_WRAP * dlt;
            end
            else if (gi == mx)
                num = hslp_pkg::HUE_GREEN * dlt + hslp_pkg::HUE_STEP * (bi - ri);
            else
                num = hslp_pkg::HUE_BLUE * dlt + hslp_pkg::HUE_STEP * (ri - gi);
            num = num / dlt;
            if (num >= hslp_pkg::HUE_WRAP)
                num -= hslp_pkg::HUE_WRAP;
            res.hue = hslp_pkg::HUE_W'(num);
        end
        return res;
    endfunction

    function automatic pixel_row_t random_pixel();
        pixel_row_t p;
        int         base;
        p = '0;
        p.r = hslp_pkg::PIX_W'($urandom_range(0, 255));
        p.g = hslp_pkg::PIX_W'($urandom_range(0, 255));
        p.b = hslp_pkg::PIX_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:
            begin
                p.g = p.r;
                p.b = p.r;
            end
            1, 2:
            begin
                // near gray: small spread around a random level
                base = int'($urandom_range(0, 252));
                p.r = hslp_pkg::PIX_W'(base + int'($urandom_range(0, 3)));
                p.g = hslp_pkg::PIX_W'(base + int'($urandom_range(0, 3)));
                p.b = hslp_pkg::PIX_W'(base + int'($urandom_range(0, 3)));
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0: p.g = p.r;
                    1: p.b = p.g;
                    default: p.b = p.r;
                endcase
            end
            4:
            begin
                p.r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                if ($urandom_range(0, 1))
                    p.b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // word accepted: queue its expected result; done: check the result against the queue head
    always @(posedge clk)
    begin
        hsl_t e;
        hsl_t got;
        if (rst_n && start && !busy)
        begin
            if (cur_row.typed)
            begin
                e.hue  = cur_row.hue;
                e.sat  = cur_row.sat;
                e.lsum = cur_row.lsum;
            end
            else
                e = hsl_convert(red, green, blue);
            hsl_expected.push_back(e);
        end
        if (rst_n && done)
        begin
            got.hue  = hue_deg;
            got.sat  = saturation_frac;
            got.lsum = lightness_sum;
            if (hsl_expected.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("ERROR: exp none, got hue=%0d sat=%0d lsum=%0d",
                             got.hue, got.sat, got.lsum);
                mismatches++;
            end
            else
            begin
                e = hsl_expected.pop_front();
                if (got !== e)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("ERROR: exp hue=%0d sat=%0d lsum=%0d, %s%0d %s%0d %s%0d",
                                 e.hue, e.sat, e.lsum, "got hue=", got.hue,
                                 "sat=", got.sat, "lsum=", got.lsum);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int burst_left;
        int gap;
        int i;
        pixel_row_t p;

        directed_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, 9'd0,   17'd0,     9'd0},
            '{8'd255, 8'd255, 8'd255, 1'b1, 9'd0,   17'd0,     9'd510},
            '{8'd255, 8'd0,   8'd0,   1'b1, 9'd0,   17'd65536, 9'd255},
            '{8'd0,   8'd255, 8'd0,   1'b1, 9'd120, 17'd65536, 9'd255},
            '{8'd0,   8'd0,   8'd255, 1'b1, 9'd240, 17'd65536, 9'd255},
            '{8'd128, 8'd128, 8'd128, 1'b1, 9'd0,   17'd0,     9'd256},
            '{8'd255, 8'd255, 8'd0,   1'b1, 9'd60,  17'd65536, 9'd255},
            '{8'd0,   8'd255, 8'd255, 1'b1, 9'd180, 17'd65536, 9'd255},
            '{8'd255, 8'd0,   8'd255, 1'b1, 9'd300, 17'd65536, 9'd255},
            '{8'd1,   8'd0,   8'd0,   1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd255, 8'd254, 8'd254, 1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd255, 8'd0,   8'd1,   1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd200, 8'd10,  8'd50,  1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd10,  8'd200, 8'd50,  1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd10,  8'd50,  8'd200, 1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd128, 8'd127, 8'd127, 1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd129, 8'd127, 8'd127, 1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd1,   8'd1,   8'd0,   1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd170, 8'd85,  8'd170, 1'b0, 9'd0,   17'd0,     9'd0},
            '{8'd85,  8'd170, 8'd85,  1'b0, 9'd0,   17'd0,     9'd0}
        };

        cur_row    = '0;
        rst_n      = 1'b0;
        start      = 1'b0;
        red        = '0;
        green      = '0;
        blue       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        burst_left = 0;
        for (i = 0; i < N_ROWS + N_RANDOM; i++)
        begin
            p = (i < N_ROWS) ? directed_rows[i] : random_pixel();
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                                         : int'($urandom_range(1, 16));
                gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            cur_row = p;
            red   <= p.r;
            green <= p.g;
            blue  <= p.b;
            start <= 1'b1;
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
            burst_left--;
        end
        start <= 1'b0;

        while (hsl_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hslp_pkg.sv
hdl/hslp_div.sv
hdl/rgb_to_hsl_pixel.sv
bench/tb_top.sv
